FILE: hdl/lceg_pkg.sv
// ----------------------------------------------------------------------------
// lceg_pkg: shared types and constants of the log-change event generator
// Field widths, register indexes, the per-pixel decision struct and the
// fixed-point natural log used to build the lookup table at elaboration.
// ----------------------------------------------------------------------------
package lceg_pkg;

    // Field widths fixed by the event format
    localparam int FW_W      = 7;
    localparam int THR_W     = 15;
    localparam int COL_W     = 7;
    localparam int ROW_W     = 7;
    localparam int EVT_W     = 15;
    localparam int M_TDATA_W = 32;

    // Row pitch of the reference store (address = row * pitch + column)
    localparam int ROW_PITCH = 128;

    // Configuration register indexes
    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH   = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_LOG_THRESHOLD = 1'd1;

    // Reset values of the configuration registers
    localparam logic [FW_W-1:0]  FW_RESET  = 7'd127;
    localparam logic [THR_W-1:0] THR_RESET = 15'd1229;

    // Row counter saturates here
    localparam logic [ROW_W-1:0] ROW_MAX = 7'd127;

    // Log table construction constants
    localparam int              GUARD_BITS = 4;
    localparam longint unsigned LN2_Q32    = 64'd2977044472;

    // Per-pixel decision handed from the compare unit to the pipeline
    typedef struct packed {
        logic fire;      // emit an event word
        logic polarity;  // reference brighter than the new pixel
        logic write;     // update the reference entry
    } lceg_dec_t;

    // ln(v) in unsigned fixed point with frac_bits fraction bits.
    // Squaring method on a Q1.30 mantissa, then scale log2 by ln2.
    function automatic longint unsigned fixed_ln(input int unsigned v,
                                                 input int unsigned frac_bits);
        int unsigned     e;
        int unsigned     fb;
        longint unsigned m;
        longint unsigned frac;
        longint unsigned l2;
        longint unsigned p;
        e    = 0;
        fb   = frac_bits + GUARD_BITS;
        frac = 64'd0;
        if (v == 0) begin
            return 64'd0;
        end
        while ((v >> (e + 1)) != 0) begin
            e++;
        end
        m = longint'(v) << (30 - e);
        for (int k = 0; k < fb; k++) begin
            m    = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31)) begin
                frac = frac | 64'd1;
                m    = m >> 1;
            end
        end
        l2 = (longint'(e) << fb) | frac;
        p  = l2 * LN2_Q32;
        return (p + (64'd1 << (32 + GUARD_BITS - 1))) >> (32 + GUARD_BITS);
    endfunction

endpackage

FILE: hdl/lceg_ref_mem.sv
// ----------------------------------------------------------------------------
// lceg_ref_mem: reference frame store
// Single-port-write, single-port-read synchronous RAM with a registered read port.
// A read and a write to the same entry at one edge returns the old data.
// ----------------------------------------------------------------------------
module lceg_ref_mem #(
    parameter int DEPTH = 16384,
    parameter int AW    = 14,
    parameter int DW    = 8
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/lceg_log_cmp.sv
// ----------------------------------------------------------------------------
// lceg_log_cmp: log-domain change detector
// Looks up ln of the reference and of the new pixel, compares the absolute
// difference to the threshold and decides on event and reference update.
// ----------------------------------------------------------------------------
module lceg_log_cmp
    import lceg_pkg::*;
#(
    parameter int PIXEL_BITS    = 8,
    parameter int LOG_FRAC_BITS = 12
) (
    input  logic [PIXEL_BITS-1:0] ref_pix,
    input  logic [PIXEL_BITS-1:0] new_pix,
    input  logic [THR_W-1:0]      log_threshold,
    input  logic                  loaded,
    output lceg_dec_t             dec
);

    localparam int LEVELS = 1 << PIXEL_BITS;
    localparam int LW     = LOG_FRAC_BITS + 4;
    localparam int CW     = (LW > THR_W) ? LW : THR_W;

    logic [LW-1:0] ln_rom [LEVELS];
    logic [LW-1:0] ln_ref;
    logic [LW-1:0] ln_new;
    logic [LW-1:0] diff;
    logic          differ;
    logic          any_zero;
    logic          over;

    // Constant ln table, built at elaboration
    for (genvar g = 0; g < LEVELS; g++)
    begin : g_ln
        assign ln_rom[g] = LW'(fixed_ln(g, LOG_FRAC_BITS));
    end

    // Absolute log difference against threshold
    always_comb
    begin
        ln_ref   = ln_rom[ref_pix];
        ln_new   = ln_rom[new_pix];
        diff     = (ln_ref > ln_new) ? (ln_ref - ln_new) : (ln_new - ln_ref);
        over     = CW'(diff) > CW'(log_threshold);
        differ   = ref_pix != new_pix;
        any_zero = (ref_pix == '0) || (new_pix == '0);
    end

    // Decision; once loaded, a changed pixel with a zero on either side always fires
    always_comb
    begin
        dec.fire     = loaded && differ && (any_zero || over);
        dec.polarity = ref_pix > new_pix;
        dec.write    = !loaded || dec.fire;
    end

endmodule

FILE: hdl/log_change_event_generator.sv
// ----------------------------------------------------------------------------
// log_change_event_generator: pixel stream to log-change address events
// Compares each raster-order pixel with a stored reference frame in the log
// domain and emits an address event when the change exceeds the threshold.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries pixels: tdata = pixel_value, tuser = start_of_frame.
//   m_* carries event words, zero or one per pixel.
//   cfg_we/cfg_index/cfg_data write frame_width (0) and log_threshold (1);
//   write them only while no pixel is in flight.
// Timing:
//   One pixel per cycle sustained while no event word is held. An event word
//   is registered for m_* as its pixel leaves the compare stage: the reference
//   RAM read is issued at the accepting edge; ln lookup, compare and write-back
//   follow in the compare stage. A write-back and the next pixel's read of the
//   same entry are resolved by a one-entry forwarding register.
// Reset:
//   Position and load flag clear; the RAM needs no clearing pass. The first
//   frame after reset only loads the reference and emits nothing.
// Back pressure:
//   A held event word leaves room for one more pixel in the compare stage;
//   s_tready drops only when both are occupied and m_tready is low.
// ----------------------------------------------------------------------------
module log_change_event_generator
    import lceg_pkg::*;
#(
    parameter int MAX_PIXELS    = 16384,
    parameter int PIXEL_BITS    = 8,
    parameter int LOG_FRAC_BITS = 12
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Configuration write port
    input  logic                                  cfg_we,
    input  logic [REG_IDX_W-1:0]                  cfg_index,
    input  logic [THR_W-1:0]                      cfg_data,
    // Pixel input
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((PIXEL_BITS + 7) / 8) * 8-1:0] s_tdata,  // pixel_value
    input  logic                                  s_tuser,  // start_of_frame
    // Event output
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // event_word[14:0], column_out[21:15], row_out[28:22], polarity[29]
    output logic [M_TDATA_W-1:0]                  m_tdata
);

    localparam int AW   = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int STEP = ROW_PITCH % MAX_PIXELS;

    // Configuration registers
    logic [FW_W-1:0]  frame_width_reg;
    logic [THR_W-1:0] log_threshold_reg;
    logic [COL_W:0]   width_eff;

    // Position state
    logic [COL_W-1:0] col_reg,  col_next;
    logic [ROW_W-1:0] row_reg,  row_next;
    logic [AW-1:0]    base_reg, base_next;
    logic [AW-1:0]    addr_reg, addr_next;
    logic             loaded_reg, loaded_next;

    // Current pixel position after start-of-frame handling
    logic             sof;
    logic [COL_W-1:0] cur_col;
    logic [ROW_W-1:0] cur_row;
    logic [AW-1:0]    cur_base;
    logic [AW-1:0]    cur_addr;
    logic             cur_loaded;
    logic [COL_W:0]   col_inc;
    logic [ROW_W-1:0] row_inc;
    logic [AW:0]      base_sum;
    logic [AW-1:0]    base_wrap;
    logic [AW:0]      addr_sum;
    logic [AW-1:0]    addr_wrap;

    // Compare stage
    logic                  p1_valid_reg, p1_valid_next;
    logic [PIXEL_BITS-1:0] p1_pix_reg;
    logic [COL_W-1:0]      p1_col_reg;
    logic [ROW_W-1:0]      p1_row_reg;
    logic [AW-1:0]         p1_addr_reg;
    logic                  p1_loaded_reg;
    logic                  fwd_valid_reg;
    logic [PIXEL_BITS-1:0] fwd_data_reg;
    logic [PIXEL_BITS-1:0] rd_data;
    logic [PIXEL_BITS-1:0] ref_pix;
    lceg_dec_t             dec;
    logic                  wr_en;

    // Output register
    logic                 out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic [COL_W-1:0]     mirror_col;

    // Handshake
    logic accept;
    logic advance;

    assign advance  = p1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !p1_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;
    assign sof      = s_tuser;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg   <= FW_RESET;
            log_threshold_reg <= THR_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:   frame_width_reg   <= cfg_data[FW_W-1:0];
                REG_LOG_THRESHOLD: log_threshold_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // A width of zero means a full 128-pixel row
    assign width_eff = (frame_width_reg == '0) ? (COL_W + 1)'(ROW_PITCH)
                                               : {1'b0, frame_width_reg};

    // Position of the pixel being accepted
    always_comb
    begin
        cur_col    = sof ? '0 : col_reg;
        cur_row    = sof ? '0 : row_reg;
        cur_base   = sof ? '0 : base_reg;
        cur_addr   = sof ? '0 : addr_reg;
        cur_loaded = loaded_reg || (sof && ((col_reg != '0) || (row_reg != '0)));

        col_inc   = {1'b0, cur_col} + 1'b1;
        row_inc   = (cur_row == ROW_MAX) ? cur_row : cur_row + 1'b1;
        base_sum  = {1'b0, cur_base} + (AW + 1)'(STEP);
        base_wrap = (base_sum >= (AW + 1)'(MAX_PIXELS))
                  ? AW'(base_sum - (AW + 1)'(MAX_PIXELS)) : AW'(base_sum);
        addr_sum  = {1'b0, cur_addr} + 1'b1;
        addr_wrap = (addr_sum >= (AW + 1)'(MAX_PIXELS)) ? '0 : AW'(addr_sum);
    end

    // Advance the position after each accepted pixel
    always_comb
    begin
        col_next    = col_reg;
        row_next    = row_reg;
        base_next   = base_reg;
        addr_next   = addr_reg;
        loaded_next = loaded_reg;
        if (accept)
        begin
            loaded_next = cur_loaded;
            if (col_inc >= width_eff)
            begin
                col_next  = '0;
                row_next  = row_inc;
                base_next = (cur_row == ROW_MAX) ? cur_base : base_wrap;
                addr_next = (cur_row == ROW_MAX) ? cur_base : base_wrap;
            end
            else
            begin
                col_next  = COL_W'(col_inc);
                row_next  = cur_row;
                base_next = cur_base;
                addr_next = addr_wrap;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            base_reg   <= '0;
            addr_reg   <= '0;
            loaded_reg <= 1'b0;
        end
        else
        begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            base_reg   <= base_next;
            addr_reg   <= addr_next;
            loaded_reg <= loaded_next;
        end
    end

    // Reference frame RAM
    assign wr_en = advance && dec.write;

    lceg_ref_mem #(
        .DEPTH (MAX_PIXELS),
        .AW    (AW),
        .DW    (PIXEL_BITS)
    ) u_ref_mem (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (cur_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (p1_addr_reg),
        .wr_data (p1_pix_reg)
    );

    // Compare stage valid
    always_comb
    begin
        p1_valid_next = p1_valid_reg;
        if (accept)
        begin
            p1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            p1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= p1_valid_next;
        end
    end

    // Compare stage payload; catch a same-entry write at the read edge
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_pix_reg    <= s_tdata[PIXEL_BITS-1:0];
            p1_col_reg    <= cur_col;
            p1_row_reg    <= cur_row;
            p1_addr_reg   <= cur_addr;
            p1_loaded_reg <= cur_loaded;
            fwd_valid_reg <= wr_en && (p1_addr_reg == cur_addr);
            fwd_data_reg  <= p1_pix_reg;
        end
    end

    assign ref_pix = fwd_valid_reg ? fwd_data_reg : rd_data;

    // Log compare and decision
    lceg_log_cmp #(
        .PIXEL_BITS    (PIXEL_BITS),
        .LOG_FRAC_BITS (LOG_FRAC_BITS)
    ) u_log_cmp (
        .ref_pix       (ref_pix),
        .new_pix       (p1_pix_reg),
        .log_threshold (log_threshold_reg),
        .loaded        (p1_loaded_reg),
        .dec           (dec)
    );

    // Event word assembly
    assign mirror_col = COL_W'(width_eff - {1'b0, p1_col_reg});

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = dec.fire;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && dec.fire)
        begin
            out_data_reg <= {2'b00, dec.polarity, p1_row_reg, mirror_col,
                             p1_row_reg, mirror_col, dec.polarity};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
